// ===== src/assert_macros.svh =====
// Assertion macros shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property holds at every clock edge outside reset.
`define ASSERT_CHK(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("assertion failed");

// Antecedent implies consequent on the next edge.
`define ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// ===== src/raa_pkg.sv =====
// ----------------------------------------------------------------------------
// raa_pkg
// Shared constants for the rectangle atlas allocator.
// ----------------------------------------------------------------------------
package raa_pkg;

  localparam int MaxRects = 128;
  localparam int MaxDim   = 4096;
  localparam int DimW     = 13;
  localparam int TotW     = 25;

  localparam logic [1:0] StatOk   = 2'd0;
  localparam logic [1:0] StatMiss = 2'd1;
  localparam logic [1:0] StatFull = 2'd2;

  localparam logic [1:0] RegAtlasW = 2'd0;
  localparam logic [1:0] RegAtlasH = 2'd1;
  localparam logic [1:0] RegMinSide = 2'd2;
  localparam logic [1:0] RegPrune  = 2'd3;

endpackage

// ===== src/raa_ram.sv =====
// ----------------------------------------------------------------------------
// raa_ram
// Generic single-port synchronous RAM with registered read.
// ----------------------------------------------------------------------------
module raa_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] addr_i,
  input  logic [Width-1:0]         wdata_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_o <= mem_q[addr_i];
  end
endmodule

// ===== src/rect_atlas_allocator.sv =====
// ----------------------------------------------------------------------------
// rect_atlas_allocator
// Guillotine packer: best-area-fit search over a free-rectangle list in RAM.
// ----------------------------------------------------------------------------
// Allocate scans the N free entries, then removes the chosen entry by moving the
//   entries after it down; pruning runs when the list exceeds the prune limit.
// Throughput: one word at a time; the single RAM port sets the pace.
// Reset: entry zero is written in the first cycle out of reset while the input
//   stalls; the list then holds one rectangle of the configured atlas, totals zero.
// The result register frees the input as soon as the result is loaded.
`include "assert_macros.svh"

module rect_atlas_allocator #(
  parameter int MaxRects = raa_pkg::MaxRects,
  parameter int MaxDim   = raa_pkg::MaxDim
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_index_i,
  input  logic [12:0] cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic        func_i,
  input  logic [12:0] req_width_i,
  input  logic [12:0] req_height_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [1:0]  status_o,
  output logic [11:0] pos_x_o,
  output logic [11:0] pos_y_o,
  output logic [24:0] used_area_o,
  output logic [24:0] grant_count_o
);
  localparam int AW = $clog2(MaxRects);
  localparam int CW = $clog2(MaxRects + 1);
  localparam int DW = raa_pkg::DimW;
  localparam int EW = 4 * DW;
  localparam logic [24:0] TotMax = '1;

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_SCAN  = 4'd1;
  localparam logic [3:0] S_SCANW = 4'd2;
  localparam logic [3:0] S_DEC   = 4'd3;
  localparam logic [3:0] S_SHR   = 4'd4;
  localparam logic [3:0] S_SHW   = 4'd5;
  localparam logic [3:0] S_APP1  = 4'd6;
  localparam logic [3:0] S_APP2  = 4'd7;
  localparam logic [3:0] S_PI    = 4'd8;
  localparam logic [3:0] S_PIW   = 4'd9;
  localparam logic [3:0] S_PJ    = 4'd10;
  localparam logic [3:0] S_PJW   = 4'd11;
  localparam logic [3:0] S_DONE  = 4'd12;
  localparam logic [3:0] S_BESTR = 4'd13;
  localparam logic [3:0] S_BESTW = 4'd14;
  localparam logic [3:0] S_INIT  = 4'd15;

  typedef struct packed {
    logic [DW-1:0] x;
    logic [DW-1:0] y;
    logic [DW-1:0] w;
    logic [DW-1:0] h;
  } rect_t;

  logic [DW-1:0] atlas_w_q, atlas_h_q, min_side_q;
  logic [7:0]    prune_q;
  logic [3:0]    state_q, state_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic [CW-1:0] idx_q, idx_d, jdx_q, jdx_d;
  logic [AW-1:0] best_q, best_d;
  logic          found_q, found_d;
  logic [25:0]   barea_q, barea_d;
  logic [DW-1:0] bshort_q, bshort_d;
  logic [DW-1:0] rw_q, rw_d, rh_q, rh_d;
  rect_t         br_q, br_d, ri_q, ri_d;
  logic          hit_q, hit_d;
  logic [24:0]   area_q, area_d, grants_q, grants_d;
  logic          ov_q, ov_d;
  logic [1:0]    st_q, st_d;
  logic [11:0]   px_q, px_d, py_q, py_d;
  logic [1:0]    wst_q, wst_d;
  logic [11:0]   wpx_q, wpx_d, wpy_q, wpy_d;
  logic [24:0]   oarea_q, oarea_d, ogrants_q, ogrants_d;

  logic          we;
  logic [AW-1:0] addr;
  rect_t         wdata, rdata;

  raa_ram #(.Width(EW), .Depth(MaxRects)) u_ram (
    .clk_i(clk_i), .we_i(we), .addr_i(addr), .wdata_i(wdata), .rdata_o(rdata)
  );

  function automatic logic [DW-1:0] clampd(input logic [DW-1:0] v);
    if (v == '0) return DW'(1);
    if (32'(v) > MaxDim) return DW'(MaxDim);
    return v;
  endfunction

  function automatic logic inside_f(input rect_t a, input rect_t b);
    return a.x >= b.x && a.y >= b.y &&
           ({1'b0, a.x} + {1'b0, a.w}) <= ({1'b0, b.x} + {1'b0, b.w}) &&
           ({1'b0, a.y} + {1'b0, a.h}) <= ({1'b0, b.y} + {1'b0, b.h});
  endfunction

  logic [DW-1:0] ms, wq, hq, dw, dh, sh;
  logic [25:0]   ar;
  logic          fits, better;
  logic [CW-1:0] added;
  logic [26:0]   sum_area;

  assign in_stall_o = (state_q != S_IDLE);
  assign out_valid_o = ov_q;
  assign status_o = st_q;
  assign pos_x_o = px_q;
  assign pos_y_o = py_q;
  assign used_area_o = oarea_q;
  assign grant_count_o = ogrants_q;

  always_comb begin
    ms = clampd(min_side_q);
    wq = (req_width_i < ms) ? ms : req_width_i;
    hq = (req_height_i < ms) ? ms : req_height_i;
    fits = (rw_q <= rdata.w) && (rh_q <= rdata.h);
    ar = 26'(rdata.w) * 26'(rdata.h);
    dw = rdata.w - rw_q;
    dh = rdata.h - rh_q;
    sh = (dw < dh) ? dw : dh;
    better = !found_q || ar < barea_q || (ar == barea_q && sh < bshort_q);
    added = CW'(br_q.w > rw_q) + CW'(br_q.h > rh_q);
    sum_area = 27'(area_q) + 27'(26'(rw_q) * 26'(rh_q));
  end

  always_comb begin
    state_d = state_q; cnt_d = cnt_q; idx_d = idx_q; jdx_d = jdx_q;
    best_d = best_q; found_d = found_q; barea_d = barea_q; bshort_d = bshort_q;
    rw_d = rw_q; rh_d = rh_q; br_d = br_q; ri_d = ri_q; hit_d = hit_q;
    area_d = area_q; grants_d = grants_q; ov_d = ov_q; st_d = st_q;
    px_d = px_q; py_d = py_q;
    wst_d = wst_q; wpx_d = wpx_q; wpy_d = wpy_q;
    oarea_d = oarea_q; ogrants_d = ogrants_q;
    we = 1'b0; addr = idx_q[AW-1:0]; wdata = rdata;
    if (ov_q && !out_stall_i) begin
      ov_d = 1'b0;
    end
    case (state_q)
      S_INIT: begin
        we = 1'b1; addr = '0;
        wdata = '{x: '0, y: '0, w: clampd(atlas_w_q), h: clampd(atlas_h_q)};
        state_d = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid_i) begin
          if (func_i) begin
            we = 1'b1; addr = '0;
            wdata = '{x: '0, y: '0, w: clampd(atlas_w_q), h: clampd(atlas_h_q)};
            cnt_d = CW'(1); area_d = '0; grants_d = '0;
            wst_d = raa_pkg::StatOk; wpx_d = '0; wpy_d = '0;
            state_d = S_DONE;
          end else begin
            rw_d = wq; rh_d = hq; found_d = 1'b0; idx_d = '0;
            state_d = S_SCAN;
          end
        end
      end
      S_SCAN: begin
        if (idx_q >= cnt_q) begin
          state_d = S_DEC;
        end else begin
          addr = idx_q[AW-1:0];
          state_d = S_SCANW;
        end
      end
      S_SCANW: begin
        if (fits && better) begin
          found_d = 1'b1; best_d = idx_q[AW-1:0]; barea_d = ar; bshort_d = sh;
        end
        idx_d = idx_q + CW'(1);
        state_d = S_SCAN;
      end
      S_DEC: begin
        if (!found_q) begin
          wst_d = raa_pkg::StatMiss; wpx_d = '0; wpy_d = '0;
          state_d = S_DONE;
        end else begin
          addr = best_q;
          state_d = S_BESTR;
        end
      end
      S_BESTR: begin
        br_d = rdata;
        state_d = S_BESTW;
      end
      S_BESTW: begin
        if (32'(cnt_q) - 1 + 32'(added) > MaxRects) begin
          wst_d = raa_pkg::StatFull; wpx_d = '0; wpy_d = '0;
          state_d = S_DONE;
        end else begin
          wst_d = raa_pkg::StatOk;
          wpx_d = br_q.x[11:0]; wpy_d = br_q.y[11:0];
          area_d = (sum_area > 27'(TotMax)) ? TotMax : sum_area[24:0];
          grants_d = (grants_q == TotMax) ? grants_q : grants_q + 25'd1;
          idx_d = CW'(best_q) + CW'(1);
          state_d = S_SHR;
        end
      end
      S_SHR: begin
        if (idx_q >= cnt_q) begin
          cnt_d = cnt_q - CW'(1);
          state_d = S_APP1;
        end else begin
          addr = idx_q[AW-1:0];
          state_d = S_SHW;
        end
      end
      S_SHW: begin
        we = 1'b1; addr = AW'(idx_q - CW'(1)); wdata = rdata;
        idx_d = idx_q + CW'(1);
        state_d = S_SHR;
      end
      S_APP1: begin
        if (br_q.w > rw_q) begin
          we = 1'b1; addr = cnt_q[AW-1:0];
          wdata = '{x: br_q.x + rw_q, y: br_q.y, w: br_q.w - rw_q, h: rh_q};
          cnt_d = cnt_q + CW'(1);
        end
        state_d = S_APP2;
      end
      S_APP2: begin
        if (br_q.h > rh_q) begin
          we = 1'b1; addr = cnt_q[AW-1:0];
          wdata = '{x: br_q.x, y: br_q.y + rh_q, w: br_q.w, h: br_q.h - rh_q};
          cnt_d = cnt_q + CW'(1);
        end
        state_d = S_PI;
        idx_d = '0;
        if (!(32'(cnt_d) > 32'(prune_q))) begin
          state_d = S_DONE;
        end
      end
      S_PI: begin
        if (idx_q >= cnt_q) begin
          state_d = S_DONE;
        end else begin
          addr = idx_q[AW-1:0];
          state_d = S_PIW;
        end
      end
      S_PIW: begin
        ri_d = rdata; jdx_d = '0; hit_d = 1'b0;
        state_d = S_PJ;
      end
      S_PJ: begin
        if (hit_q) begin
          if (jdx_q >= cnt_q) begin
            cnt_d = cnt_q - CW'(1);
            state_d = S_PI;
          end else begin
            addr = jdx_q[AW-1:0];
            found_d = 1'b1;
            state_d = S_PJW;
          end
        end else if (jdx_q >= cnt_q) begin
          idx_d = idx_q + CW'(1);
          state_d = S_PI;
        end else begin
          addr = jdx_q[AW-1:0];
          found_d = 1'b0;
          state_d = S_PJW;
        end
      end
      S_PJW: begin
        if (found_q) begin
          we = 1'b1; addr = AW'(jdx_q - CW'(1)); wdata = rdata;
          jdx_d = jdx_q + CW'(1);
        end else if (jdx_q != idx_q && inside_f(ri_q, rdata)) begin
          hit_d = 1'b1;
          jdx_d = idx_q + CW'(1);
        end else begin
          jdx_d = jdx_q + CW'(1);
        end
        state_d = S_PJ;
      end
      S_DONE: begin
        if (!ov_q || !out_stall_i) begin
          ov_d = 1'b1;
          st_d = wst_q; px_d = wpx_q; py_d = wpy_q;
          oarea_d = area_q; ogrants_d = grants_q;
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      atlas_w_q <= DW'(1024); atlas_h_q <= DW'(1024);
      min_side_q <= DW'(4); prune_q <= 8'd100;
      state_q <= S_INIT; cnt_q <= CW'(1); area_q <= '0; grants_q <= '0;
      ov_q <= 1'b0; found_q <= 1'b0; hit_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_index_i)
          raa_pkg::RegAtlasW:  atlas_w_q <= cfg_data_i;
          raa_pkg::RegAtlasH:  atlas_h_q <= cfg_data_i;
          raa_pkg::RegMinSide: min_side_q <= cfg_data_i;
          raa_pkg::RegPrune:   prune_q <= cfg_data_i[7:0];
          default: ;
        endcase
      end
      state_q <= state_d; cnt_q <= cnt_d; area_q <= area_d; grants_q <= grants_d;
      ov_q <= ov_d; found_q <= found_d; hit_q <= hit_d;
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q <= idx_d; jdx_q <= jdx_d; best_q <= best_d; barea_q <= barea_d;
    bshort_q <= bshort_d; rw_q <= rw_d; rh_q <= rh_d; br_q <= br_d;
    ri_q <= ri_d; st_q <= st_d; px_q <= px_d; py_q <= py_d;
    wst_q <= wst_d; wpx_q <= wpx_d; wpy_q <= wpy_d;
    oarea_q <= oarea_d; ogrants_q <= ogrants_d;
  end

  `ASSERT_CHK(a_cnt_range, 32'(cnt_q) <= MaxRects)
  `ASSERT_CHK(a_stall_busy, (state_q != S_IDLE) |-> in_stall_o)
  `ASSERT_NEXT(a_grant_mono, ov_q && st_q == raa_pkg::StatOk && !out_stall_i
    && state_q == S_IDLE && !in_valid_i, $stable(grants_q))

endmodule

// ===== sim/raa_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// raa_checker
// Watches the allocator channels, keeps its own free-rectangle list and
// compares every result word against the predicted grant.
// ----------------------------------------------------------------------------
module raa_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_index_i,
  input  logic [12:0] cfg_data_i,
  input  logic        in_valid_i,
  input  logic        in_stall_i,
  input  logic        func_i,
  input  logic [12:0] req_width_i,
  input  logic [12:0] req_height_i,
  input  logic        out_valid_i,
  input  logic        out_stall_i,
  input  logic [1:0]  status_i,
  input  logic [11:0] pos_x_i,
  input  logic [11:0] pos_y_i,
  input  logic [24:0] used_area_i,
  input  logic [24:0] grant_count_i,
  output int          fail_count_o,
  output int          pending_o
);
  localparam int unsigned TotMax = (1 << raa_pkg::TotW) - 1;

  typedef struct {
    int unsigned x, y, w, h;
  } free_rect_t;

  typedef struct {
    logic [1:0]  status;
    logic [11:0] pos_x;
    logic [11:0] pos_y;
    logic [24:0] used_area;
    logic [24:0] grant_count;
  } grant_t;

  logic [12:0] atlas_w, atlas_h, min_side;
  logic [7:0]  prune_lim;
  free_rect_t  free_list [raa_pkg::MaxRects];
  int unsigned free_cnt, area_sum, grant_sum;
  grant_t      grant_q [$];

  function automatic int unsigned clamp_dim(int unsigned v);
    if (v == 0) return 1;
    if (v > raa_pkg::MaxDim) return raa_pkg::MaxDim;
    return v;
  endfunction

  function automatic void clear_atlas();
    free_list[0] = '{0, 0, clamp_dim(atlas_w), clamp_dim(atlas_h)};
    free_cnt  = 1;
    area_sum  = 0;
    grant_sum = 0;
  endfunction

  function automatic void drop_entry(int unsigned idx);
    for (int unsigned k = idx; k + 1 < free_cnt; k++) free_list[k] = free_list[k + 1];
    free_cnt--;
  endfunction

  function automatic bit contained(free_rect_t a, free_rect_t b);
    return a.x >= b.x && a.y >= b.y && a.x + a.w <= b.x + b.w && a.y + a.h <= b.y + b.h;
  endfunction

  function automatic void prune_list();
    int unsigned i;
    bit hit;
    i = 0;
    while (i < free_cnt) begin
      hit = 0;
      for (int unsigned j = 0; j < free_cnt && !hit; j++)
        if (j != i && contained(free_list[i], free_list[j])) hit = 1;
      if (hit) drop_entry(i);
      else i++;
    end
  endfunction

  function automatic grant_t place_rect(logic func, logic [12:0] rw, logic [12:0] rh);
    grant_t          g;
    int unsigned     ms, w, h, best, s, dw, dh, added, cnt;
    longint unsigned a, best_a, ar;
    int unsigned     best_s;
    bit              found;
    free_rect_t      r, n;
    g = '{raa_pkg::StatOk, 0, 0, 0, 0};
    if (func) begin
      clear_atlas();
    end else begin
      ms = clamp_dim(min_side);
      w = (rw < ms) ? ms : rw;
      h = (rh < ms) ? ms : rh;
      found = 0; best = 0; best_a = 0; best_s = 0;
      for (int unsigned i = 0; i < free_cnt; i++) begin
        r = free_list[i];
        if (w > r.w || h > r.h) continue;
        a = longint'(r.w) * r.h;
        dw = r.w - w;
        dh = r.h - h;
        s = (dw < dh) ? dw : dh;
        if (!found || a < best_a || (a == best_a && s < best_s)) begin
          found = 1; best = i; best_a = a; best_s = s;
        end
      end
      if (!found) begin
        g.status = raa_pkg::StatMiss;
      end else begin
        r = free_list[best];
        added = (r.w > w ? 1 : 0) + (r.h > h ? 1 : 0);
        cnt = free_cnt - 1 + added;
        if (cnt > raa_pkg::MaxRects) begin
          g.status = raa_pkg::StatFull;
        end else begin
          g.pos_x = r.x[11:0];
          g.pos_y = r.y[11:0];
          drop_entry(best);
          if (r.w > w) begin
            n = '{r.x + w, r.y, r.w - w, h};
            free_list[free_cnt++] = n;
          end
          if (r.h > h) begin
            n = '{r.x, r.y + h, r.w, r.h - h};
            free_list[free_cnt++] = n;
          end
          if (free_cnt > prune_lim) prune_list();
          ar = longint'(area_sum) + longint'(w) * h;
          area_sum = (ar > TotMax) ? TotMax : 32'(ar);
          if (grant_sum < TotMax) grant_sum++;
        end
      end
    end
    g.used_area   = area_sum[24:0];
    g.grant_count = grant_sum[24:0];
    return g;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    grant_t exp_g;
    if (!rst_ni) begin
      atlas_w      = 13'd1024;
      atlas_h      = 13'd1024;
      min_side     = 13'd4;
      prune_lim    = 8'd100;
      clear_atlas();
      grant_q.delete();
      fail_count_o = 0;
      pending_o    = 0;
    end else begin
      if (out_valid_i && !out_stall_i) begin
        if (grant_q.size() == 0) begin
          $error("result word with no request pending");
          fail_count_o++;
        end else begin
          exp_g = grant_q.pop_front();
          if (status_i !== exp_g.status) begin
            $error("status: expected %0d, got %0d", exp_g.status, status_i);
            fail_count_o++;
          end
          if (pos_x_i !== exp_g.pos_x) begin
            $error("pos_x: expected %0d, got %0d", exp_g.pos_x, pos_x_i);
            fail_count_o++;
          end
          if (pos_y_i !== exp_g.pos_y) begin
            $error("pos_y: expected %0d, got %0d", exp_g.pos_y, pos_y_i);
            fail_count_o++;
          end
          if (used_area_i !== exp_g.used_area) begin
            $error("used_area: expected %0d, got %0d", exp_g.used_area, used_area_i);
            fail_count_o++;
          end
          if (grant_count_i !== exp_g.grant_count) begin
            $error("grant_count: expected %0d, got %0d", exp_g.grant_count,
                   grant_count_i);
            fail_count_o++;
          end
        end
      end
      if (in_valid_i && !in_stall_i)
        grant_q.insert(grant_q.size(), place_rect(func_i, req_width_i, req_height_i));
      if (cfg_we_i) begin
        case (cfg_index_i)
          raa_pkg::RegAtlasW:  atlas_w   = cfg_data_i;
          raa_pkg::RegAtlasH:  atlas_h   = cfg_data_i;
          raa_pkg::RegMinSide: min_side  = cfg_data_i;
          raa_pkg::RegPrune:   prune_lim = cfg_data_i[7:0];
          default: ;
        endcase
      end
      pending_o = grant_q.size();
    end
  end

endmodule

// ===== sim/testbench.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Drives allocate and clear words into the atlas allocator across several
// atlas, minimum-side and prune settings, with random gaps and stalls and
// one long output hold-off; the checker beside the block gives the count.
// ----------------------------------------------------------------------------
module testbench;

  localparam int CycleLimit = 300000000;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we_i = 1'b0;
  logic [1:0]  cfg_index_i = '0;
  logic [12:0] cfg_data_i = '0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  logic        func_i = 1'b0;
  logic [12:0] req_width_i = '0;
  logic [12:0] req_height_i = '0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic [1:0]  status_o;
  logic [11:0] pos_x_o, pos_y_o;
  logic [24:0] used_area_o, grant_count_o;
  int          fail_count, pending;
  int          cycles = 0;
  bit          quiet = 0;
  bit          hold_go = 0;

  rect_atlas_allocator u_top (.*);

  raa_checker u_chk (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_index_i, .cfg_data_i,
    .in_valid_i, .in_stall_i(in_stall_o), .func_i, .req_width_i, .req_height_i,
    .out_valid_i(out_valid_o), .out_stall_i, .status_i(status_o),
    .pos_x_i(pos_x_o), .pos_y_i(pos_y_o), .used_area_i(used_area_o),
    .grant_count_i(grant_count_o), .fail_count_o(fail_count), .pending_o(pending)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("Verification failed");
      $finish;
    end
  end

  function automatic int gap_len();
    if (quiet) return 0;
    if ($urandom_range(0, 9) == 0) return $urandom_range(20, 80);
    return $urandom_range(0, 2);
  endfunction

  initial begin
    int n;
    @(posedge rst_ni);
    forever begin
      if (hold_go) begin
        hold_go = 0;
        out_stall_i <= 1'b1;
        repeat (3000) @(posedge clk_i);
      end else if (quiet || $urandom_range(0, 1) == 0) begin
        out_stall_i <= 1'b0;
        n = quiet ? 1 : $urandom_range(1, 20);
        repeat (n) @(posedge clk_i);
      end else begin
        out_stall_i <= 1'b1;
        n = gap_len() + 1;
        repeat (n) @(posedge clk_i);
      end
    end
  end

  task automatic send_word(logic func, logic [12:0] w, logic [12:0] h);
    int g;
    g = gap_len();
    if (g > 0) begin
      in_valid_i <= 1'b0;
      repeat (g) @(posedge clk_i);
    end
    in_valid_i   <= 1'b1;
    func_i       <= func;
    req_width_i  <= w;
    req_height_i <= h;
    do @(posedge clk_i); while (in_stall_o);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [12:0] val);
    in_valid_i  <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
  endtask

  task automatic setup(logic [12:0] aw, logic [12:0] ah, logic [12:0] ms, logic [12:0] pl);
    write_reg(raa_pkg::RegAtlasW, aw);
    write_reg(raa_pkg::RegAtlasH, ah);
    write_reg(raa_pkg::RegMinSide, ms);
    write_reg(raa_pkg::RegPrune, pl);
    send_word(1'b1, 13'($urandom), 13'($urandom));
  endtask

  initial begin
    int          count, hi;
    logic [12:0] aw, ah, ms, pl;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_word(1'b0, 13'd0, 13'd0);
    send_word(1'b0, 13'd4096, 13'd10);
    send_word(1'b0, 13'd1000, 13'd1);
    send_word(1'b0, 13'd1, 13'd1000);
    send_word(1'b1, 13'h1fff, 13'h1fff);
    send_word(1'b0, 13'd1024, 13'd1024);
    send_word(1'b0, 13'd1, 13'd1);
    setup(13'd0, 13'd5000, 13'd0, 13'd0);
    send_word(1'b0, 13'd1, 13'd1);
    send_word(1'b0, 13'd1, 13'd4096);
    send_word(1'b0, 13'd2, 13'd1);
    send_word(1'b0, 13'd1, 13'd7);
    setup(13'd4096, 13'd4096, 13'd5000, 13'd255);
    send_word(1'b0, 13'd0, 13'd0);
    send_word(1'b0, 13'd1, 13'd1);
    setup(13'd8191, 13'd1, 13'd1, 13'd128);
    send_word(1'b0, 13'd4095, 13'd1);
    send_word(1'b0, 13'd1, 13'd1);
    send_word(1'b0, 13'd1, 13'd1);

    for (int ph = 0; ph < 7; ph++) begin
      case (ph)
        0: begin aw = 13'd1024; ah = 13'd1024; ms = 13'd4; pl = 13'd100; hi = 200; end
        1: begin aw = 13'd64; ah = 13'd64; ms = 13'd1; pl = 13'd128; hi = 6; end
        2: begin aw = 13'd4096; ah = 13'd4096; ms = 13'd16; pl = 13'd20; hi = 1024; end
        3: begin aw = 13'd1; ah = 13'd1; ms = 13'd1; pl = 13'd1; hi = 2; end
        4: begin aw = 13'd300; ah = 13'd200; ms = 13'd8; pl = 13'd0; hi = 64; end
        5: begin
          aw = 13'($urandom_range(1, 4096));
          ah = 13'($urandom_range(1, 4096));
          ms = 13'($urandom_range(1, 32));
          pl = 13'($urandom_range(0, 255));
          hi = int'(aw > ah ? aw : ah) / 4 + 1;
        end
        default: begin aw = 13'd128; ah = 13'd128; ms = 13'd2; pl = 13'd255; hi = 10; end
      endcase
      setup(aw, ah, ms, pl);
      quiet = (ph == 0 || ph == 6);
      if (ph == 1) hold_go = 1;
      count = (ph == 1 || ph == 6) ? 320 : 220;
      for (int k = 0; k < count; k++) begin
        case ($urandom_range(0, 39))
          0:       send_word(1'b1, 13'($urandom), 13'($urandom));
          1, 2:    send_word(1'b0, 13'($urandom_range(0, 4096)),
                             13'($urandom_range(0, 4096)));
          default: send_word(1'b0, 13'($urandom_range(0, hi)),
                             13'($urandom_range(0, hi)));
        endcase
      end
    end
    in_valid_i <= 1'b0;
    quiet = 0;

    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (50) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
